/* hw/rtl/skt_pkg.sv */
// Shared types, constants and codes for the sorted key table.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package skt_pkg;

  localparam int TABLE_DEPTH  = 32;
  localparam int PAYLOAD_BITS = 64;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  // Fixed field widths of the channels
  localparam int MODE_W          = 2;
  localparam int TIME_W          = 32;
  localparam int KEY_PAYLOAD_W   = 64;
  localparam int TOL_W           = 31;
  localparam int READ_IDX_W      = 5;
  localparam int STATUS_W        = 3;
  localparam int ENTRY_COUNT_W   = 6;

  // About 0.0001 s in Q16.16
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7);

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE         = 3'd0,
    ST_REJECTED     = 3'd1,
    ST_FULL         = 3'd2,
    ST_NONE_REMOVED = 3'd3,
    ST_BAD_INDEX    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_CMP  = 2'd1,
    OP_DROP = 2'd2,
    OP_INS  = 2'd3
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CMP  = 2'd1,
    S_EDIT = 2'd2
  } state_e;

  typedef struct packed {
    logic signed [TIME_W-1:0] key_time;
    logic [PAYLOAD_BITS-1:0]  payload;
  } entry_t;

  typedef struct packed {
    cell_op_e                 op;
    logic signed [TIME_W-1:0] key_time;
    logic [TOL_W-1:0]         tol;
    logic [PAYLOAD_BITS-1:0]  payload;
    logic [IDX_W-1:0]         rd_idx;
  } cell_cmd_t;

  typedef struct packed {
    logic   any_match;
    entry_t rd_entry;
  } chain_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/skt_if.sv */
// Valid/ready channel interfaces for the key table's request and result beats.
// Depends on skt_pkg for field widths.
`default_nettype none

interface skt_in_if;
  import skt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [TIME_W-1:0] key_time;
  logic [KEY_PAYLOAD_W-1:0] key_payload;
  logic                     replace_allowed;
  logic [TOL_W-1:0]         remove_tolerance;
  logic [READ_IDX_W-1:0]    read_index;

  modport source (
    output valid, mode, key_time, key_payload, replace_allowed,
           remove_tolerance, read_index,
    input  ready
  );
  modport sink (
    input  valid, mode, key_time, key_payload, replace_allowed,
           remove_tolerance, read_index,
    output ready
  );
endinterface

interface skt_out_if;
  import skt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [ENTRY_COUNT_W-1:0] entry_count;
  logic signed [TIME_W-1:0] out_time;
  logic [KEY_PAYLOAD_W-1:0] out_payload;

  modport source (
    output valid, status, entry_count, out_time, out_payload,
    input  ready
  );
  modport sink (
    input  valid, status, entry_count, out_time, out_payload,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/skt_cell.sv */
// One slot of the sorted chain: holds a key, compares it, shifts to/from neighbours.
// Depends on skt_pkg.
`default_nettype none

module skt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  skt_pkg::cell_cmd_t  cmd_i,
  input  logic                occupied_i,
  input  logic                left_after_i,
  input  logic                prior_hit_i,
  input  skt_pkg::entry_t     left_i,
  input  skt_pkg::entry_t     right_i,
  output skt_pkg::entry_t     entry_o,
  output logic                match_o,
  output logic                after_o
);
  import skt_pkg::*;

  entry_t               entry_q, entry_d;
  logic                 match_q, after_q;
  logic [TIME_W:0]      diff;
  logic [TIME_W:0]      mag;
  logic                 in_tol;
  logic                 later;

  // Exact 33-bit distance, inclusive tolerance
  always_comb begin
    diff   = {entry_q.key_time[TIME_W-1], entry_q.key_time}
           - {cmd_i.key_time[TIME_W-1], cmd_i.key_time};
    mag    = diff[TIME_W] ? (~diff + (TIME_W+1)'(1)) : diff;
    in_tol = mag <= (TIME_W+1)'(cmd_i.tol);
    later  = $signed(entry_q.key_time) > $signed(cmd_i.key_time);
  end

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      OP_DROP: begin
        if (prior_hit_i || match_q) entry_d = right_i;
      end
      OP_INS: begin
        if (after_q) begin
          if (left_after_i) begin
            entry_d = left_i;
          end else begin
            entry_d.key_time = cmd_i.key_time;
            entry_d.payload  = cmd_i.payload;
          end
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      after_q <= 1'b0;
    end else if (cmd_i.op == OP_CMP) begin
      match_q <= occupied_i && in_tol;
      after_q <= !occupied_i || later;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;
  assign after_o = after_q;

endmodule

`default_nettype wire

/* hw/rtl/skt_ctrl.sv */
// Sequencer of the key table: takes request beats, steps the cell chain, holds the result.
// Depends on skt_pkg and the channel interfaces in skt_if.
`default_nettype none

module skt_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_wr_en_i,
  input  logic [skt_pkg::TOL_W-1:0]      cfg_wr_data_i,
  skt_in_if.sink                         in_i,
  skt_out_if.source                      out_o,
  input  skt_pkg::chain_stat_t           stat_i,
  output skt_pkg::cell_cmd_t             cmd_o,
  output logic [skt_pkg::CNT_W-1:0]      count_o
);
  import skt_pkg::*;

  state_e                   state_q, state_d;
  mode_e                    mode_q;
  logic signed [TIME_W-1:0] time_q;
  logic [PAYLOAD_BITS-1:0]  payload_q;
  logic                     repl_q;
  logic [TOL_W-1:0]         rtol_q;
  logic [TOL_W-1:0]         mtol_q;
  logic [READ_IDX_W-1:0]    ridx_q;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     place_q, removed_q;

  logic                     out_valid_q;
  status_e                  status_q;
  logic [ENTRY_COUNT_W-1:0] ocount_q;
  logic signed [TIME_W-1:0] otime_q;
  logic [KEY_PAYLOAD_W-1:0] opay_q;

  logic                     accept, out_free;
  logic                     drop_req, ins_req, fin, fin_go, rd_ok;
  status_e                  fin_status;

  assign accept   = in_i.valid && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_o.ready;

  // Decide the edit step from the registered compare flags
  always_comb begin
    drop_req   = 1'b0;
    ins_req    = 1'b0;
    fin        = 1'b0;
    rd_ok      = 1'b0;
    fin_status = ST_DONE;
    if (state_q == S_EDIT) begin
      case (mode_q)
        MODE_INSERT: begin
          if (place_q) begin
            ins_req = 1'b1;
          end else if (stat_i.any_match) begin
            if (repl_q) begin
              drop_req = 1'b1;
            end else begin
              fin        = 1'b1;
              fin_status = ST_REJECTED;
            end
          end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
            fin        = 1'b1;
            fin_status = ST_FULL;
          end else begin
            ins_req = 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (stat_i.any_match) begin
            drop_req = 1'b1;
          end else begin
            fin        = 1'b1;
            fin_status = removed_q ? ST_DONE : ST_NONE_REMOVED;
          end
        end
        MODE_READ: begin
          fin = 1'b1;
          if (CNT_W'(ridx_q) < count_q) rd_ok = 1'b1;
          else fin_status = ST_BAD_INDEX;
        end
        default: fin = 1'b1;
      endcase
      if (ins_req) fin = 1'b1;
    end
    fin_go = fin && out_free;
  end

  // Command to the cells
  always_comb begin
    cmd_o.op = OP_HOLD;
    if ((state_q == S_IDLE && accept) || state_q == S_CMP) cmd_o.op = OP_CMP;
    else if (drop_req) cmd_o.op = OP_DROP;
    else if (ins_req && fin_go) cmd_o.op = OP_INS;

    if (state_q == S_IDLE) begin
      cmd_o.key_time = in_i.key_time;
      cmd_o.tol      = (mode_e'(in_i.mode) == MODE_REMOVE) ? in_i.remove_tolerance : mtol_q;
    end else begin
      cmd_o.key_time = time_q;
      cmd_o.tol      = (mode_q == MODE_REMOVE) ? rtol_q : mtol_q;
    end
    cmd_o.payload = payload_q;
    cmd_o.rd_idx  = IDX_W'(ridx_q);
  end

  always_comb begin
    count_d = count_q;
    if (drop_req) count_d = count_q - CNT_W'(1);
    else if (ins_req && fin_go) count_d = count_q + CNT_W'(1);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EDIT;
      end
      S_CMP: state_d = S_EDIT;
      S_EDIT: begin
        if (drop_req) state_d = S_CMP;
        else if (fin_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      mtol_q      <= TOL_RESET;
      place_q     <= 1'b0;
      removed_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_wr_en_i) mtol_q <= cfg_wr_data_i;
      if (accept) begin
        place_q   <= 1'b0;
        removed_q <= 1'b0;
      end else if (drop_req) begin
        place_q   <= (mode_q == MODE_INSERT);
        removed_q <= 1'b1;
      end
      if (fin_go) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Operand and result payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= mode_e'(in_i.mode);
      time_q    <= in_i.key_time;
      payload_q <= in_i.key_payload[PAYLOAD_BITS-1:0];
      repl_q    <= in_i.replace_allowed;
      rtol_q    <= in_i.remove_tolerance;
      ridx_q    <= in_i.read_index;
    end
    if (fin_go) begin
      status_q <= fin_status;
      ocount_q <= ENTRY_COUNT_W'(count_d);
      otime_q  <= rd_ok ? stat_i.rd_entry.key_time : '0;
      opay_q   <= rd_ok ? KEY_PAYLOAD_W'(stat_i.rd_entry.payload) : '0;
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.entry_count = ocount_q;
  assign out_o.out_time    = otime_q;
  assign out_o.out_payload = opay_q;
  assign count_o           = count_q;

endmodule

`default_nettype wire

/* hw/rtl/sorted_key_table_top.sv */
// Top level of the sorted key table: sequencer plus a chain of key cells.
// Depends on skt_pkg, skt_if, skt_cell and skt_ctrl.
//
// Usage
//   in_i  : request beats (insert, remove or read), valid/ready.
//   out_o : one result beat per request: status, key count after the
//           operation, and the entry read (zeros for anything but a good read).
//   cfg_wr_en_i / cfg_wr_data_i : write the insert match tolerance; write it
//           only while no request is in flight.
// Timing
//   Every cell compares its key with the request time in the accept cycle.
//   The edit state that follows shifts the chain (at most one shift per cell)
//   and registers the result once the output register is free; a plain
//   insert, a rejected or full insert and a read end there, and the next
//   beat is taken only once the previous one is through. A replacing
//   insert runs drop, re-compare, insert; a remove that deletes k keys
//   runs k drop/re-compare rounds, one key per compare/shift pair.
// Reset
//   The table comes up empty with the match tolerance at 7 (about 0.1 ms).
// Back-pressure
//   The result sits in an output register; a new request is taken while it
//   waits, and that request's final step waits for the register to free.
`default_nettype none

module sorted_key_table_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wr_en_i,
  input  logic [skt_pkg::TOL_W-1:0]  cfg_wr_data_i,
  skt_in_if.sink                     in_i,
  skt_out_if.source                  out_o
);
  import skt_pkg::*;

  cell_cmd_t              cmd;
  chain_stat_t            stat;
  logic [CNT_W-1:0]       count;

  entry_t                 cell_ent [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match;
  logic [TABLE_DEPTH-1:0] after;
  logic [TABLE_DEPTH-1:0] occ;
  logic [TABLE_DEPTH:0]   hit_chain;
  entry_t                 rd_ent;

  skt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_i          (in_i),
    .out_o         (out_o),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .count_o       (count)
  );

  // Hit ripple: a cell drops on its own match or on any match below it
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_after;

    if (i == 0) begin : g_first
      assign left_ent   = '0;
      assign left_after = 1'b0;
    end else begin : g_mid
      assign left_ent   = cell_ent[i-1];
      assign left_after = after[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_ent = cell_ent[i];
    end else begin : g_inner
      assign right_ent = cell_ent[i+1];
    end

    assign occ[i]         = CNT_W'(i) < count;
    assign hit_chain[i+1] = hit_chain[i] | match[i];

    skt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .occupied_i   (occ[i]),
      .left_after_i (left_after),
      .prior_hit_i  (hit_chain[i]),
      .left_i       (left_ent),
      .right_i      (right_ent),
      .entry_o      (cell_ent[i]),
      .match_o      (match[i]),
      .after_o      (after[i])
    );
  end

  // Read port: pick the addressed cell
  always_comb begin
    rd_ent = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cmd.rd_idx == IDX_W'(i)) rd_ent = cell_ent[i];
    end
  end

  assign stat.any_match = hit_chain[TABLE_DEPTH];
  assign stat.rd_entry  = rd_ent;

endmodule

`default_nettype wire

/* hw/rtl/skt_checker.sv */
// Port-level assertions for the sorted key table, bound to the top level.
// Depends on skt_pkg and sorted_key_table_top.
`default_nettype none

module skt_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_i,
  input logic                                  out_valid_i,
  input logic                                  out_ready_i,
  input logic [skt_pkg::STATUS_W-1:0]          status_i,
  input logic [skt_pkg::ENTRY_COUNT_W-1:0]     entry_count_i,
  input logic [skt_pkg::TIME_W-1:0]            out_time_i,
  input logic [skt_pkg::KEY_PAYLOAD_W-1:0]     out_payload_i
);
  import skt_pkg::*;

  // One request at a time: no beat taken in the cycle after a beat
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("request taken while previous one still in flight");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (entry_count_i <= ENTRY_COUNT_W'(TABLE_DEPTH)))
    else $error("entry count beyond table depth");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i == ST_FULL) |-> (entry_count_i == ENTRY_COUNT_W'(TABLE_DEPTH)))
    else $error("table full reported with room left");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i != ST_DONE) |-> (out_time_i == '0 && out_payload_i == '0))
    else $error("failed operation returned entry data");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(status_i)
                                       && $stable(entry_count_i) && $stable(out_time_i)
                                       && $stable(out_payload_i)))
    else $error("stalled result beat changed");

endmodule

bind sorted_key_table_top skt_checker u_skt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .entry_count_i (out_o.entry_count),
  .out_time_i    (out_o.out_time),
  .out_payload_i (out_o.out_payload)
);

`default_nettype wire

/* verif/sorted_key_table_top_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for sorted_key_table_top: random and directed insert, remove,
// read beats with a shadow table in a scoreboard class. Needs skt_pkg, skt_if, the RTL.

import skt_pkg::*;

typedef struct {
  mode_e                     mode;
  logic signed [TIME_W-1:0]  key_time;
  logic [KEY_PAYLOAD_W-1:0]  key_payload;
  logic                      replace_allowed;
  logic [TOL_W-1:0]          remove_tolerance;
  logic [READ_IDX_W-1:0]     read_index;
} key_request_t;

typedef struct {
  logic [STATUS_W-1:0]       status;
  logic [ENTRY_COUNT_W-1:0]  entry_count;
  logic signed [TIME_W-1:0]  out_time;
  logic [KEY_PAYLOAD_W-1:0]  out_payload;
} key_result_t;

// Shadow copy of the key table; every accepted request updates it and queues
// the answer the block has to give.
class key_table_tracker;
  logic signed [TIME_W-1:0] held_times [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0]  held_payloads [TABLE_DEPTH];
  int                       held_count;
  logic [TOL_W-1:0]         match_tol;
  key_result_t              pending_results [$];
  int unsigned              failures;

  function new();
    held_count = 0;
    match_tol  = TOL_RESET;
    failures   = 0;
  endfunction

  function bit near(logic signed [TIME_W-1:0] a, logic signed [TIME_W-1:0] b,
                    logic [TOL_W-1:0] tol);
    longint span;
    span = longint'(a) - longint'(b);
    if (span < 0) span = -span;
    return span <= longint'(tol);
  endfunction

  function void place_sorted(logic signed [TIME_W-1:0] t, logic [PAYLOAD_BITS-1:0] p);
    int pos;
    pos = held_count;
    while (pos > 0 && held_times[pos-1] > t) begin
      held_times[pos]    = held_times[pos-1];
      held_payloads[pos] = held_payloads[pos-1];
      pos--;
    end
    held_times[pos]    = t;
    held_payloads[pos] = p;
    held_count++;
  endfunction

  function void drop_at(int idx);
    for (int i = idx; i + 1 < held_count; i++) begin
      held_times[i]    = held_times[i+1];
      held_payloads[i] = held_payloads[i+1];
    end
    held_count--;
  endfunction

  function void note_request(key_request_t req);
    key_result_t want;
    int          hit;
    int          kept;
    want.status      = ST_DONE;
    want.out_time    = '0;
    want.out_payload = '0;
    case (req.mode)
      MODE_INSERT: begin
        hit = -1;
        for (int i = 0; i < held_count; i++) begin
          if (hit < 0 && near(held_times[i], req.key_time, match_tol)) hit = i;
        end
        if (hit >= 0) begin
          if (!req.replace_allowed) begin
            want.status = ST_REJECTED;
          end else begin
            drop_at(hit);
            place_sorted(req.key_time, req.key_payload);
          end
        end else if (held_count >= TABLE_DEPTH) begin
          want.status = ST_FULL;
        end else begin
          place_sorted(req.key_time, req.key_payload);
        end
      end
      MODE_REMOVE: begin
        kept = 0;
        for (int i = 0; i < held_count; i++) begin
          if (!near(held_times[i], req.key_time, req.remove_tolerance)) begin
            held_times[kept]    = held_times[i];
            held_payloads[kept] = held_payloads[i];
            kept++;
          end
        end
        if (kept == held_count) want.status = ST_NONE_REMOVED;
        held_count = kept;
      end
      MODE_READ: begin
        if (int'(req.read_index) < held_count) begin
          want.out_time    = held_times[req.read_index];
          want.out_payload = held_payloads[req.read_index];
        end else begin
          want.status = ST_BAD_INDEX;
        end
      end
      default: ;
    endcase
    want.entry_count = ENTRY_COUNT_W'(held_count);
    pending_results = {pending_results, want};
  endfunction

  function void check_result(key_result_t got);
    key_result_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result beat: status %0d, entry_count %0d", got.status,
             got.entry_count);
      failures++;
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      failures++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      failures++;
    end
    if (got.out_time !== want.out_time) begin
      $error("out_time: expected %0d, got %0d", want.out_time, got.out_time);
      failures++;
    end
    if (got.out_payload !== want.out_payload) begin
      $error("out_payload: expected %h, got %h", want.out_payload, got.out_payload);
      failures++;
    end
  endfunction
endclass

module sorted_key_table_top_test;

  localparam logic signed [TIME_W-1:0] TIME_MIN = 32'sh8000_0000;
  localparam logic signed [TIME_W-1:0] TIME_MAX = 32'sh7FFF_FFFF;
  localparam logic [TOL_W-1:0]         TOL_MAX  = '1;
  localparam logic [KEY_PAYLOAD_W-1:0] ALL_ONES = '1;
  localparam int                       PHASE_BEATS = 180;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [TOL_W-1:0] cfg_wr_data;

  skt_in_if  req_ch ();
  skt_out_if res_ch ();

  key_table_tracker tracker = new();

  // steady_run switches every idle and stall off for one phase
  bit          steady_run;
  int unsigned next_gap;
  int unsigned stall_left;

  sorted_key_table_top uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data),
    .in_i          (req_ch),
    .out_o         (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (full-table removes, long stalls).
  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

  // Mostly back-to-back or short idles, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (steady_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Favour times around a cluster and around held keys so that matches and
  // removes actually bite; keep some fully random and extreme times.
  function automatic logic signed [TIME_W-1:0] pick_time();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return TIME_W'(int'($urandom_range(0, 400)) - 200);
    if (r < 45 && tracker.held_count > 0)
      return tracker.held_times[$urandom_range(0, tracker.held_count - 1)] +
             TIME_W'(int'($urandom_range(0, 20)) - 10);
    if (r < 55) begin
      case ($urandom_range(0, 5))
        0:       return TIME_MIN;
        1:       return TIME_MIN + 1;
        2:       return TIME_MAX;
        3:       return TIME_MAX - 1;
        4:       return '0;
        default: return '1;
      endcase
    end
    return TIME_W'($urandom);
  endfunction

  function automatic logic [TOL_W-1:0] pick_remove_tol();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return TOL_W'($urandom_range(0, 30));
    if (r < 75) return TOL_W'($urandom_range(0, 70000));
    if (r < 92) return TOL_W'($urandom);
    return TOL_MAX;
  endfunction

  function automatic logic [READ_IDX_W-1:0] pick_read_index();
    if (tracker.held_count > 0 && $urandom_range(0, 99) < 70)
      return READ_IDX_W'($urandom_range(0, tracker.held_count - 1));
    return READ_IDX_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [KEY_PAYLOAD_W-1:0] pick_payload();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return ALL_ONES;
    return {$urandom, $urandom};
  endfunction

  // Drive one request beat and note it at the accepting edge. Valid stays high
  // after the beat only when the next one follows straight away, so it is
  // never dropped and raised within one time step.
  task automatic issue(input mode_e m, input logic signed [TIME_W-1:0] t,
                       input logic [KEY_PAYLOAD_W-1:0] p, input logic repl,
                       input logic [TOL_W-1:0] rtol, input logic [READ_IDX_W-1:0] ridx);
    key_request_t req;
    req.mode             = m;
    req.key_time         = t;
    req.key_payload      = p;
    req.replace_allowed  = repl;
    req.remove_tolerance = rtol;
    req.read_index       = ridx;
    if (next_gap > 0) repeat (next_gap) @(posedge clk);
    req_ch.valid            <= 1'b1;
    req_ch.mode             <= m;
    req_ch.key_time         <= t;
    req_ch.key_payload      <= p;
    req_ch.replace_allowed  <= repl;
    req_ch.remove_tolerance <= rtol;
    req_ch.read_index       <= ridx;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    tracker.note_request(req);
    next_gap = idle_gap();
    if (next_gap > 0) req_ch.valid <= 1'b0;
  endtask

  // Drop valid before anything that needs the request side quiet; with a gap
  // pending, valid is already low.
  task automatic hold_requests();
    if (next_gap == 0) begin
      req_ch.valid <= 1'b0;
      next_gap = 1;
    end
  endtask

  // Write the match tolerance once every outstanding result has come back.
  task automatic write_match_tolerance(input logic [TOL_W-1:0] tol);
    hold_requests();
    while (tracker.pending_results.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= tol;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.match_tol = tol;
  endtask

  task automatic random_phase(input int beats, input int insert_pct);
    int rest;
    int remove_cut;
    int read_cut;
    int r;
    rest       = 100 - insert_pct;
    remove_cut = insert_pct + rest * 35 / 100;
    read_cut   = remove_cut + rest * 55 / 100;
    repeat (beats) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct)
        issue(MODE_INSERT, pick_time(), pick_payload(), 1'($urandom_range(0, 1)),
              TOL_W'($urandom), READ_IDX_W'($urandom));
      else if (r < remove_cut)
        issue(MODE_REMOVE, pick_time(), pick_payload(), 1'($urandom_range(0, 1)),
              pick_remove_tol(), READ_IDX_W'($urandom));
      else if (r < read_cut)
        issue(MODE_READ, pick_time(), pick_payload(), 1'($urandom_range(0, 1)),
              TOL_W'($urandom), pick_read_index());
      else
        issue(MODE_NOP, pick_time(), pick_payload(), 1'($urandom_range(0, 1)),
              TOL_W'($urandom), READ_IDX_W'($urandom));
    end
  endtask

  // Result side: check each beat taken, then pick ready for the next cycle.
  initial begin
    key_result_t got;
    res_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        got.status      = res_ch.status;
        got.entry_count = res_ch.entry_count;
        got.out_time    = res_ch.out_time;
        got.out_payload = res_ch.out_payload;
        tracker.check_result(got);
      end
      if (!steady_run && stall_left == 0 && $urandom_range(0, 99) < 30)
        stall_left = idle_gap();
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [TOL_W-1:0] phase_tol [6];
    int               phase_insert_pct [6];
    steady_run = 1'b0;
    next_gap   = 0;
    phase_tol        = '{TOL_W'(0), TOL_RESET, TOL_W'(65536), TOL_MAX, TOL_W'($urandom),
                         TOL_W'(300)};
    phase_insert_pct = '{80, 55, 50, 45, 55, 70};

    // Hold every input at a known value through reset.
    rst_n                   <= 1'b0;
    cfg_wr_en               <= 1'b0;
    cfg_wr_data             <= '0;
    req_ch.valid            <= 1'b0;
    req_ch.mode             <= MODE_INSERT;
    req_ch.key_time         <= '0;
    req_ch.key_payload      <= '0;
    req_ch.replace_allowed  <= 1'b0;
    req_ch.remove_tolerance <= '0;
    req_ch.read_index       <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extremes, reject and replace at the reset tolerance.
    write_match_tolerance(TOL_RESET);
    issue(MODE_READ, '0, '0, 1'b0, '0, READ_IDX_W'(0));           // read of an empty table
    issue(MODE_REMOVE, '0, '0, 1'b0, '0, '0);                     // nothing to remove
    issue(MODE_NOP, TIME_MAX, ALL_ONES, 1'b1, TOL_MAX, '1);       // unused mode
    issue(MODE_INSERT, TIME_MIN, '0, 1'b0, '0, '0);
    issue(MODE_INSERT, TIME_MAX, ALL_ONES, 1'b0, '0, '0);
    issue(MODE_INSERT, '0, 64'h0123_4567_89AB_CDEF, 1'b0, '0, '0);
    issue(MODE_INSERT, TIME_W'(5), pick_payload(), 1'b0, '0, '0); // matches 0, rejected
    issue(MODE_INSERT, -TIME_W'(3), pick_payload(), 1'b1, '0, '0); // replaces 0
    for (int i = 0; i < 3; i++) issue(MODE_READ, '0, '0, 1'b0, '0, READ_IDX_W'(i));
    issue(MODE_READ, '0, '0, 1'b0, '0, READ_IDX_W'(31));          // far out of range
    issue(MODE_READ, '0, '0, 1'b0, '0, READ_IDX_W'(3));           // just past the end

    // Two keys closer than the later tolerance, then a replace that lands on
    // a time already held: the moved key must sit after its twin.
    write_match_tolerance(TOL_W'(0));
    issue(MODE_INSERT, TIME_W'(1000), pick_payload(), 1'b0, '0, '0);
    issue(MODE_INSERT, TIME_W'(1008), pick_payload(), 1'b0, '0, '0);
    write_match_tolerance(TOL_W'(10));
    issue(MODE_INSERT, TIME_W'(1008), pick_payload(), 1'b1, '0, '0);
    issue(MODE_READ, '0, '0, 1'b0, '0, READ_IDX_W'(2));
    issue(MODE_READ, '0, '0, 1'b0, '0, READ_IDX_W'(3));

    // Widest tolerance: inclusive edge of the distance, and a sweeping remove.
    write_match_tolerance(TOL_MAX);
    issue(MODE_INSERT, '0, pick_payload(), 1'b0, '0, '0);
    issue(MODE_REMOVE, '0, '0, 1'b0, TOL_MAX, '0);
    issue(MODE_READ, '0, '0, 1'b0, '0, READ_IDX_W'(0));
    issue(MODE_REMOVE, TIME_MIN, '0, 1'b0, '0, '0);

    // Random phases, one per tolerance; the first fills the table to the top,
    // the third runs with no idles or stalls at all.
    for (int ph = 0; ph < 6; ph++) begin
      write_match_tolerance(phase_tol[ph]);
      steady_run = (ph == 2);
      random_phase(PHASE_BEATS, phase_insert_pct[ph]);
    end

    // Drain, then keep the clock running so any stray beat can still show up.
    hold_requests();
    steady_run = 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/skt_pkg.sv
hw/rtl/skt_if.sv
hw/rtl/skt_cell.sv
hw/rtl/skt_ctrl.sv
hw/rtl/sorted_key_table_top.sv
hw/rtl/skt_checker.sv
verif/sorted_key_table_top_test.sv
